[design/hmwb_pkg.sv]
package hmwb_pkg;

	// Number of sensor channels carried by each beat.
	localparam int unsigned NCH = 4;
	// Default window length and bucket length.
	localparam int unsigned WINDOW_LEN_DEF = 24;
	localparam logic [16:0] BUCKET_SECONDS_RST = 17'd3600;
	// Saturation point of the per-bucket sample count.
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	// Divider step counts for the bucket number and the channel means.
	localparam logic [5:0] DIV_STEPS_BUCKET = 6'd32;
	localparam logic [5:0] DIV_STEPS_MEAN = 6'd48;

	// Operation codes.
	localparam logic [1:0] OP_FEED = 2'd0;
	localparam logic [1:0] OP_READ = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0] op;
		logic [31:0] timestamp;
		logic sample_valid;
		logic signed [31:0] temperature_in;
		logic signed [31:0] humidity_in;
		logic signed [31:0] co_in;
		logic signed [31:0] no2_in;
	} in_beat_t;

	typedef struct packed {
		logic window_ready;
		logic finalized;
		logic [4:0] filled_slots;
		logic [4:0] slot_index;
		logic signed [31:0] mean_temperature;
		logic signed [31:0] mean_humidity;
		logic signed [31:0] mean_co;
		logic signed [31:0] mean_no2;
		logic last;
	} out_beat_t;

	// One ring slot: the four channel means, channel 0 first.
	typedef logic [NCH-1:0][31:0] means_t;

	// Divider request from the sequencer.
	typedef struct packed {
		logic start;
		logic [47:0] dividend;
		logic [16:0] divisor;
		logic [5:0] steps;
	} div_req_t;

endpackage

[design/hmwb_div.sv]
module hmwb_div (
	input logic clk,
	input logic arst_n,
	input hmwb_pkg::div_req_t req,
	output logic done,
	output logic [47:0] quotient
);
	import hmwb_pkg::*;

	logic [47:0] work_q;
	logic [16:0] rem_q;
	logic [16:0] div_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [17:0] trial;
	logic ge;

	// One restoring step: bring in the next dividend bit and try a subtract.
	assign trial = {rem_q, work_q[47]};
	assign ge = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= req.steps;
				work_q <= req.dividend;
				rem_q <= '0;
				div_q <= req.divisor;
			end else if (busy_q) begin
				work_q <= {work_q[46:0], ge};
				rem_q <= ge ? 17'(trial - {1'b0, div_q}) : trial[16:0];
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	// Quotient bits collect at the bottom of the shifting word.
	assign quotient = work_q;

endmodule

[design/hmwb_ram.sv]
module hmwb_ram #(
	parameter int unsigned DEPTH = hmwb_pkg::WINDOW_LEN_DEF,
	parameter int unsigned AW = $clog2(DEPTH)
) (
	input logic clk,
	input logic wr_en,
	input logic [AW-1:0] wr_addr,
	input hmwb_pkg::means_t wr_data,
	input logic [AW-1:0] rd_addr,
	output hmwb_pkg::means_t rd_data
);
	import hmwb_pkg::*;

	means_t mem [DEPTH];

	// Slot store with a registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

[design/hourly_mean_window_buffer.sv]
// Time-bucketed average buffer for four sensor channels.
// The input channel (in_valid, in_stall, in_data) takes feed, read and clear
// beats; the output channel (out_valid, out_stall, out_data) returns results.
// The single register bucket_seconds is written with cfg_we and cfg_wdata and
// resets to 3600; the user must write it only while the block is idle, as
// the block itself does not enforce this. A feed beat runs the serial bucket
// division, then accumulation and the result. A feed that closes a non-empty
// bucket adds four 48-step divisions for the means. All divisions go through
// one shared restoring divider, one quotient bit per cycle. A read beat of a
// full window gives WINDOW_LEN results, one slot at a time, as each slot
// comes from the registered read port of the slot memory; otherwise a read,
// and a clear, give one result.
// Only one beat is worked on at a time; in_stall is high meanwhile.
// An output register holds each result until the receiver takes it; while
// out_stall is high the held result stays steady and no new one is loaded.
// Reset empties the window and the running sums; slot contents are only
// read once they have been written again.
module hourly_mean_window_buffer #(
	parameter int unsigned WINDOW_LEN = hmwb_pkg::WINDOW_LEN_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input hmwb_pkg::in_beat_t in_data,
	output logic out_valid,
	input logic out_stall,
	output hmwb_pkg::out_beat_t out_data,
	input logic cfg_we,
	input logic [16:0] cfg_wdata
);
	import hmwb_pkg::*;

	localparam int unsigned AW = $clog2(WINDOW_LEN);
	localparam int unsigned CW = $clog2(WINDOW_LEN + 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_BDIV,
		S_BWAIT,
		S_DECIDE,
		S_MDIV,
		S_MWAIT,
		S_PUSH,
		S_ACCUM,
		S_FEMIT,
		S_RADDR,
		S_REMIT,
		S_SEMIT
	} state_t;

	state_t state_q;
	in_beat_t item_q;
	logic [16:0] bsec_q;
	logic [31:0] bucket_q;
	logic [31:0] cur_q;
	logic [31:0] last_q;
	logic acc_q;
	logic have_q;
	logic fin_q;
	logic [15:0] count_q;
	logic signed [47:0] sums_q [NCH];
	means_t means_q;
	logic [1:0] ch_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] rptr_q;
	logic [AW-1:0] t_q;
	logic [CW-1:0] filled_q;
	logic out_valid_q;
	out_beat_t out_q;

	div_req_t div_req;
	logic div_done;
	logic [47:0] div_quot;
	logic signed [47:0] cur_sum;
	logic [47:0] sum_mag;
	logic [31:0] mean_val;
	logic gap;
	logic [AW-1:0] wr_addr;
	logic wr_en;
	means_t rd_data;
	logic out_free;
	logic full;
	logic emit;

	// Control and payload bookkeeping.
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign out_free = !out_valid_q || !out_stall;
	assign full = (filled_q == CW'(WINDOW_LEN));
	assign emit = out_free &&
		(state_q == S_FEMIT || state_q == S_REMIT || state_q == S_SEMIT);

	// Divider operand selection.
	assign cur_sum = sums_q[ch_q];
	assign sum_mag = cur_sum[47] ? 48'(-cur_sum) : 48'(cur_sum);
	assign mean_val = cur_sum[47] ? 32'(-div_quot[31:0]) : div_quot[31:0];

	always_comb begin
		div_req = '0;
		if (state_q == S_BDIV) begin
			div_req.start = 1'b1;
			div_req.dividend = {item_q.timestamp, 16'd0};
			div_req.divisor = (bsec_q == '0) ? 17'd1 : bsec_q;
			div_req.steps = DIV_STEPS_BUCKET;
		end else if (state_q == S_MDIV) begin
			div_req.start = 1'b1;
			div_req.dividend = sum_mag;
			div_req.divisor = {1'b0, count_q};
			div_req.steps = DIV_STEPS_MEAN;
		end
	end

	// Ring write: a gap in bucket numbers restarts the ring at slot zero.
	assign gap = have_q && (cur_q != last_q + 32'd1);
	assign wr_addr = gap ? '0 : head_q;
	assign wr_en = (state_q == S_PUSH);

	hmwb_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.done(div_done),
		.quotient(div_quot)
	);

	hmwb_ram #(
		.DEPTH(WINDOW_LEN),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(means_q),
		.rd_addr(rptr_q),
		.rd_data(rd_data)
	);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsec_q <= BUCKET_SECONDS_RST;
		end else if (cfg_we) begin
			bsec_q <= cfg_wdata;
		end
	end

	// Sequencer with its state and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_q <= '0;
			last_q <= '0;
			acc_q <= 1'b0;
			have_q <= 1'b0;
			fin_q <= 1'b0;
			count_q <= '0;
			for (int c = 0; c < NCH; c++) begin
				sums_q[c] <= '0;
			end
			ch_q <= '0;
			head_q <= '0;
			rptr_q <= '0;
			t_q <= '0;
			filled_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A result stays valid until taken, and a new one is loaded when free.
			out_valid_q <= emit || (out_valid_q && out_stall);
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						item_q <= in_data;
						fin_q <= 1'b0;
						case (in_data.op)
							OP_FEED: state_q <= S_BDIV;
							OP_READ: begin
								rptr_q <= head_q;
								t_q <= '0;
								state_q <= full ? S_RADDR : S_SEMIT;
							end
							OP_CLEAR: begin
								cur_q <= '0;
								last_q <= '0;
								acc_q <= 1'b0;
								have_q <= 1'b0;
								count_q <= '0;
								for (int c = 0; c < NCH; c++) begin
									sums_q[c] <= '0;
								end
								head_q <= '0;
								filled_q <= '0;
								state_q <= S_SEMIT;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_BDIV: state_q <= S_BWAIT;
				S_BWAIT: begin
					if (div_done) begin
						bucket_q <= div_quot[31:0];
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (acc_q && bucket_q != cur_q) begin
						fin_q <= 1'b1;
						acc_q <= 1'b0;
						if (count_q == '0) begin
							// An empty bucket breaks the window.
							have_q <= 1'b0;
							filled_q <= '0;
							head_q <= '0;
							state_q <= S_ACCUM;
						end else begin
							ch_q <= '0;
							state_q <= S_MDIV;
						end
					end else begin
						state_q <= S_ACCUM;
					end
					if (!acc_q || bucket_q != cur_q) begin
						for (int c = 0; c < NCH; c++) begin
							sums_q[c] <= sums_q[c];
						end
					end
				end
				S_MDIV: state_q <= S_MWAIT;
				S_MWAIT: begin
					if (div_done) begin
						means_q[ch_q] <= mean_val;
						ch_q <= ch_q + 2'd1;
						state_q <= (ch_q == 2'(NCH - 1)) ? S_PUSH : S_MDIV;
					end
				end
				S_PUSH: begin
					head_q <= (wr_addr == AW'(WINDOW_LEN - 1)) ? '0 : wr_addr + AW'(1);
					if (gap) begin
						filled_q <= CW'(1);
					end else if (!full) begin
						filled_q <= filled_q + CW'(1);
					end
					last_q <= cur_q;
					have_q <= 1'b1;
					state_q <= S_ACCUM;
				end
				S_ACCUM: begin
					// Open a new bucket where needed, then add the sample.
					if (!acc_q || fin_q) begin
						cur_q <= bucket_q;
						acc_q <= 1'b1;
						if (item_q.sample_valid) begin
							sums_q[0] <= 48'(item_q.temperature_in);
							sums_q[1] <= 48'(item_q.humidity_in);
							sums_q[2] <= 48'(item_q.co_in);
							sums_q[3] <= 48'(item_q.no2_in);
							count_q <= 16'd1;
						end else begin
							for (int c = 0; c < NCH; c++) begin
								sums_q[c] <= '0;
							end
							count_q <= '0;
						end
					end else if (item_q.sample_valid && count_q != COUNT_MAX) begin
						sums_q[0] <= sums_q[0] + 48'(item_q.temperature_in);
						sums_q[1] <= sums_q[1] + 48'(item_q.humidity_in);
						sums_q[2] <= sums_q[2] + 48'(item_q.co_in);
						sums_q[3] <= sums_q[3] + 48'(item_q.no2_in);
						count_q <= count_q + 16'd1;
					end
					state_q <= S_FEMIT;
				end
				S_FEMIT: begin
					if (out_free) begin
						out_q <= '{window_ready: full, finalized: fin_q,
							filled_slots: 5'(filled_q), slot_index: 5'd0,
							mean_temperature: 32'sd0, mean_humidity: 32'sd0,
							mean_co: 32'sd0, mean_no2: 32'sd0, last: 1'b1};
						state_q <= S_IDLE;
					end
				end
				S_RADDR: state_q <= S_REMIT;
				S_REMIT: begin
					if (out_free) begin
						out_q <= '{window_ready: 1'b1, finalized: 1'b0,
							filled_slots: 5'(filled_q), slot_index: 5'(t_q),
							mean_temperature: rd_data[0], mean_humidity: rd_data[1],
							mean_co: rd_data[2], mean_no2: rd_data[3],
							last: (t_q == AW'(WINDOW_LEN - 1))};
						t_q <= t_q + AW'(1);
						rptr_q <= (rptr_q == AW'(WINDOW_LEN - 1)) ? '0 : rptr_q + AW'(1);
						state_q <= (t_q == AW'(WINDOW_LEN - 1)) ? S_IDLE : S_RADDR;
					end
				end
				S_SEMIT: begin
					if (out_free) begin
						out_q <= '{window_ready: 1'b0, finalized: 1'b0,
							filled_slots: 5'(filled_q), slot_index: 5'd0,
							mean_temperature: 32'sd0, mean_humidity: 32'sd0,
							mean_co: 32'sd0, mean_no2: 32'sd0, last: 1'b1};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The fill count never passes the window length.
	assert property (@(posedge clk) disable iff (!arst_n) filled_q <= CW'(WINDOW_LEN))
		else $error("fill count beyond window length");

	// Only a full-window read gives a result that is not the last.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.last) |-> out_data.window_ready)
		else $error("non-final result outside a window read");

	// The divider finishes only while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_BWAIT || state_q == S_MWAIT))
		else $error("divider result not awaited");

endmodule

[dv/tb_hourly_mean_window_buffer.sv]
`timescale 1ns / 100ps

module tb_hourly_mean_window_buffer;
	import hmwb_pkg::*;

	localparam int unsigned WLEN = 24;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_beat_t in_data;
	logic out_valid;
	logic out_stall;
	out_beat_t out_data;
	logic cfg_we;
	logic [16:0] cfg_wdata;

	hourly_mean_window_buffer #(.WINDOW_LEN(WLEN)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Predictor state, a copy of what the block keeps.
	logic [16:0] bucket_len;
	logic signed [31:0] ring_means [WLEN][NCH];
	int unsigned ring_head;
	int unsigned ring_count;
	logic signed [47:0] run_sums [NCH];
	logic [15:0] sample_count;
	logic [31:0] open_bucket;
	bit bucket_open;
	logic [31:0] closed_bucket;
	bit any_closed;

	in_beat_t pending_beats[$];
	out_beat_t expected_results[$];
	int unsigned mismatches;
	bit flood;
	bit drain_done;
	bit in_fire;

	// Empty every part of the averaging state.
	task automatic wipe_averages();
		ring_head = 0;
		ring_count = 0;
		for (int c = 0; c < NCH; c++) run_sums[c] = '0;
		sample_count = '0;
		open_bucket = '0;
		bucket_open = 0;
		closed_bucket = '0;
		any_closed = 0;
	endtask

	// Work out the results that one accepted beat should produce.
	task automatic predict_results(input in_beat_t b);
		out_beat_t r;
		logic [31:0] div;
		logic [31:0] bkt;
		logic signed [63:0] q;
		bit fin;
		r = '0;
		case (b.op)
			OP_FEED: begin
				div = (bucket_len == 0) ? 32'd1 : {15'd0, bucket_len};
				bkt = b.timestamp / div;
				fin = 0;
				if (!bucket_open || bkt != open_bucket) begin
					if (bucket_open) begin
						fin = 1;
						if (sample_count == 0) begin
							any_closed = 0;
							ring_count = 0;
							ring_head = 0;
						end else begin
							if (any_closed && open_bucket != closed_bucket + 32'd1) begin
								ring_count = 0;
								ring_head = 0;
							end
							for (int c = 0; c < NCH; c++) begin
								q = 64'(run_sums[c]) / $signed({48'd0, sample_count});
								ring_means[ring_head][c] = q[31:0];
							end
							ring_head = (ring_head + 1) % WLEN;
							if (ring_count < WLEN) ring_count++;
							closed_bucket = open_bucket;
							any_closed = 1;
						end
					end
					for (int c = 0; c < NCH; c++) run_sums[c] = '0;
					sample_count = '0;
					open_bucket = bkt;
					bucket_open = 1;
				end
				if (b.sample_valid && sample_count != COUNT_MAX) begin
					run_sums[0] += 48'(b.temperature_in);
					run_sums[1] += 48'(b.humidity_in);
					run_sums[2] += 48'(b.co_in);
					run_sums[3] += 48'(b.no2_in);
					sample_count++;
				end
				r.window_ready = (ring_count >= WLEN);
				r.finalized = fin;
				r.filled_slots = 5'(ring_count);
				r.last = 1'b1;
				expected_results.push_back(r);
			end
			OP_READ: begin
				if (ring_count < WLEN) begin
					r.filled_slots = 5'(ring_count);
					r.last = 1'b1;
					expected_results.push_back(r);
				end else begin
					for (int t = 0; t < WLEN; t++) begin
						r = '0;
						r.window_ready = 1'b1;
						r.filled_slots = 5'(ring_count);
						r.slot_index = 5'(t);
						r.mean_temperature = ring_means[(ring_head + t) % WLEN][0];
						r.mean_humidity = ring_means[(ring_head + t) % WLEN][1];
						r.mean_co = ring_means[(ring_head + t) % WLEN][2];
						r.mean_no2 = ring_means[(ring_head + t) % WLEN][3];
						r.last = (t == WLEN - 1);
						expected_results.push_back(r);
					end
				end
			end
			OP_CLEAR: begin
				wipe_averages();
				r.last = 1'b1;
				expected_results.push_back(r);
			end
			default: begin
			end
		endcase
	endtask

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Source driver: presents queued beats, changing at the falling edge.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (pending_beats.size() != 0 && (flood || $urandom_range(99) >= 19)) begin
				in_data <= pending_beats.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Sink stall, random outside the flood stretch.
	always @(negedge clk) begin
		out_stall <= arst_n && !flood && ($urandom_range(99) < 19);
	end

	// Monitor: predicts on each accepted input beat and checks each result beat.
	always @(posedge clk) begin
		out_beat_t want;
		in_fire <= arst_n && in_valid && !in_stall;
		if (arst_n) begin
			if (in_valid && !in_stall) predict_results(in_data);
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result beat %p", out_data);
				end else begin
					want = expected_results.pop_front();
					if (out_data !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch: expected %p, got %p", want, out_data);
					end
				end
			end
		end
	end

	function automatic in_beat_t feed_beat(input logic [31:0] ts, input bit vld);
		in_beat_t b;
		b.op = OP_FEED;
		b.timestamp = ts;
		b.sample_valid = vld;
		b.temperature_in = $urandom;
		b.humidity_in = $urandom;
		b.co_in = $urandom;
		b.no2_in = $urandom;
		return b;
	endfunction

	function automatic in_beat_t op_beat(input logic [1:0] op);
		in_beat_t b;
		b = feed_beat($urandom, 1'($urandom_range(1)));
		b.op = op;
		return b;
	endfunction

	// Let the queue drain and the block settle before touching the register.
	task automatic settle();
		while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic set_bucket_len(input logic [16:0] v);
		settle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		bucket_len = (v == 0) ? 17'd0 : v;
	endtask

	// Random phase: runs of consecutive buckets with some noise.
	task automatic random_phase(input int unsigned n);
		logic [31:0] bkt;
		logic [31:0] len;
		int unsigned k;
		len = (bucket_len == 0) ? 32'd1 : {15'd0, bucket_len};
		bkt = $urandom / len;
		k = 0;
		while (k < n) begin
			int unsigned sel;
			sel = $urandom_range(99);
			if (sel < 75) begin
				repeat ($urandom_range(1, 3)) begin
					pending_beats.push_back(feed_beat(bkt * len + $urandom_range(len - 1),
						$urandom_range(9) != 0));
					k++;
				end
				bkt++;
			end else if (sel < 87) begin
				pending_beats.push_back(op_beat(OP_READ));
				k++;
			end else if (sel < 90) begin
				pending_beats.push_back(op_beat(OP_CLEAR));
				k++;
			end else if (sel < 92) begin
				pending_beats.push_back(op_beat(OP_UNUSED));
			end else begin
				pending_beats.push_back(feed_beat($urandom, 1'($urandom_range(1))));
				bkt = $urandom / len;
				k++;
			end
		end
	endtask

	// Stimulus.
	initial begin
		in_beat_t b;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		flood = 0;
		drain_done = 0;
		mismatches = 0;
		bucket_len = BUCKET_SECONDS_RST;
		wipe_averages();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes, every operation, wrap, invalid buckets.
		pending_beats.push_back(op_beat(OP_READ));
		b = feed_beat(32'd0, 1);
		b.temperature_in = 32'sh7FFFFFFF; b.humidity_in = 32'sh80000000;
		b.co_in = '1; b.no2_in = '0;
		pending_beats.push_back(b);
		b.temperature_in = 32'sh80000000; b.humidity_in = 32'sh80000000;
		pending_beats.push_back(b);
		pending_beats.push_back(feed_beat(32'd3600, 0));
		pending_beats.push_back(feed_beat(32'd7200, 1));
		pending_beats.push_back(feed_beat(32'd18000, 1));
		pending_beats.push_back(feed_beat(32'hFFFFFFFF, 1));
		pending_beats.push_back(op_beat(OP_UNUSED));
		pending_beats.push_back(op_beat(OP_CLEAR));
		set_bucket_len(17'd1);
		pending_beats.push_back(feed_beat(32'hFFFFFFFF, 1));
		pending_beats.push_back(feed_beat(32'd0, 1));
		pending_beats.push_back(feed_beat(32'd1, 1));
		for (int i = 2; i < 28; i++) pending_beats.push_back(feed_beat(32'(i), 1));
		pending_beats.push_back(op_beat(OP_READ));
		set_bucket_len(17'd0);
		random_phase(60);
		set_bucket_len(17'd86400);
		random_phase(40);
		set_bucket_len(17'h1FFFF);
		random_phase(40);
		set_bucket_len(17'd7);
		flood = 1;
		random_phase(60);
		settle();
		flood = 0;
		random_phase(70);
		settle();
		drain_done = 1;
	end

	// Final verdict.
	initial begin
		wait (drain_done);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#8000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
